// ===== src/pmlc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and register codes for the pattern match block.
package pmlc_pkg;

    localparam int BYTE_W   = 8;
    localparam int LINE_W   = 24;
    localparam int COLUMN_W = 16;
    localparam int OFFSET_W = 32;
    localparam int LEN_W    = 6;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 3;
    localparam int WORD_BYTES = 8;
    localparam int NUM_WORDS  = 4;

    typedef logic [BYTE_W-1:0]   byte_t;
    typedef logic [LINE_W-1:0]   line_t;
    typedef logic [COLUMN_W-1:0] column_t;
    typedef logic [OFFSET_W-1:0] offset_t;
    typedef logic [LEN_W-1:0]    len_t;

    localparam byte_t   NEWLINE_BYTE = 8'h0A;
    localparam line_t   LINE_MAX     = '1;
    localparam column_t COLUMN_MAX   = '1;
    localparam offset_t OFFSET_MAX   = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LENGTH = 3'd0,
        REG_PATTERN_WORD_A = 3'd1,
        REG_PATTERN_WORD_B = 3'd2,
        REG_PATTERN_WORD_C = 3'd3,
        REG_PATTERN_WORD_D = 3'd4
    } reg_index_t;

    // One result item as produced by the compare logic.
    typedef struct packed {
        logic    found;
        line_t   line;
        column_t column;
        offset_t offset;
    } match_result_t;

endpackage

// ===== src/pmlc_cfg_regs.sv =====
`timescale 1ns / 1ps
// Configuration registers: pattern length and the four pattern words.
module pmlc_cfg_regs
    import pmlc_pkg::*;
#(
    parameter int MAX_PATTERN = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_wdata,
    output len_t                        pattern_len,
    output logic [BYTE_W*MAX_PATTERN-1:0] pattern_bits
);

    len_t                              len_reg;
    logic [CFG_W-1:0]                  word_reg [NUM_WORDS];
    logic [CFG_W*NUM_WORDS-1:0]        all_bits;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
            for (int i = 0; i < NUM_WORDS; i++) begin
                word_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            case (reg_index_t'(cfg_index))
                REG_PATTERN_LENGTH: len_reg     <= cfg_wdata[LEN_W-1:0];
                REG_PATTERN_WORD_A: word_reg[0] <= cfg_wdata;
                REG_PATTERN_WORD_B: word_reg[1] <= cfg_wdata;
                REG_PATTERN_WORD_C: word_reg[2] <= cfg_wdata;
                REG_PATTERN_WORD_D: word_reg[3] <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign all_bits     = {word_reg[3], word_reg[2], word_reg[1], word_reg[0]};
    assign pattern_len  = len_reg;
    assign pattern_bits = all_bits[BYTE_W*MAX_PATTERN-1:0];

endmodule

// ===== src/pmlc_window.sv =====
`timescale 1ns / 1ps
// Text window shift line with per-byte line and column history and position counters.
module pmlc_window
    import pmlc_pkg::*;
#(
    parameter int MAX_PATTERN = 32,
    localparam int FILL_W = $clog2(MAX_PATTERN + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  byte_t             text_byte,
    input  logic              start_of_text,
    output byte_t             win_byte   [MAX_PATTERN],
    output line_t             win_line   [MAX_PATTERN],
    output column_t           win_column [MAX_PATTERN],
    output logic [FILL_W-1:0] fill,
    output offset_t           item_offset
);

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(MAX_PATTERN);

    byte_t             byte_reg   [MAX_PATTERN];
    line_t             line_reg   [MAX_PATTERN];
    column_t           column_reg [MAX_PATTERN];
    logic [FILL_W-1:0] fill_reg, fill_next;
    line_t             cur_line_reg, cur_line_next;
    column_t           cur_column_reg, cur_column_next;
    offset_t           cur_offset_reg, cur_offset_next;
    offset_t           item_offset_reg, item_offset_next;
    line_t             base_line;
    column_t           base_column;
    offset_t           base_offset;

    // A start of text restarts the position from zero before this byte is placed.
    always_comb begin
        base_line   = start_of_text ? '0 : cur_line_reg;
        base_column = start_of_text ? '0 : cur_column_reg;
        base_offset = start_of_text ? '0 : cur_offset_reg;

        if (start_of_text) begin
            fill_next = FILL_W'(1);
        end else if (fill_reg != FILL_FULL) begin
            fill_next = fill_reg + FILL_W'(1);
        end else begin
            fill_next = fill_reg;
        end

        if (text_byte == NEWLINE_BYTE) begin
            cur_line_next   = (base_line != LINE_MAX) ? base_line + LINE_W'(1) : base_line;
            cur_column_next = '0;
        end else begin
            cur_line_next   = base_line;
            cur_column_next = (base_column != COLUMN_MAX) ? base_column + COLUMN_W'(1)
                                                          : base_column;
        end
        cur_offset_next  = (base_offset != OFFSET_MAX) ? base_offset + OFFSET_W'(1)
                                                       : base_offset;
        item_offset_next = base_offset;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg        <= '0;
            cur_line_reg    <= '0;
            cur_column_reg  <= '0;
            cur_offset_reg  <= '0;
            item_offset_reg <= '0;
        end else if (load) begin
            fill_reg        <= fill_next;
            cur_line_reg    <= cur_line_next;
            cur_column_reg  <= cur_column_next;
            cur_offset_reg  <= cur_offset_next;
            item_offset_reg <= item_offset_next;
        end
    end

    // Window entries are only read once the fill count covers them.
    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg[0]   <= text_byte;
            line_reg[0]   <= base_line;
            column_reg[0] <= base_column;
            for (int i = 1; i < MAX_PATTERN; i++) begin
                byte_reg[i]   <= byte_reg[i-1];
                line_reg[i]   <= line_reg[i-1];
                column_reg[i] <= column_reg[i-1];
            end
        end
    end

    assign win_byte    = byte_reg;
    assign win_line    = line_reg;
    assign win_column  = column_reg;
    assign fill        = fill_reg;
    assign item_offset = item_offset_reg;

endmodule

// ===== src/pmlc_match.sv =====
`timescale 1ns / 1ps
// Parallel compare of the window against the pattern and start position lookup.
module pmlc_match
    import pmlc_pkg::*;
#(
    parameter int MAX_PATTERN = 32,
    localparam int FILL_W = $clog2(MAX_PATTERN + 1),
    localparam int IDX_W  = $clog2(MAX_PATTERN)
) (
    input  len_t                          pattern_len,
    input  logic [BYTE_W*MAX_PATTERN-1:0] pattern_bits,
    input  byte_t                         win_byte   [MAX_PATTERN],
    input  line_t                         win_line   [MAX_PATTERN],
    input  column_t                       win_column [MAX_PATTERN],
    input  logic [FILL_W-1:0]             fill,
    input  offset_t                       item_offset,
    output match_result_t                 result
);

    localparam len_t MAX_LEN = LEN_W'(MAX_PATTERN);

    byte_t                  pat_byte [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] byte_ok;
    logic                   len_ok;
    len_t                   pidx;
    len_t                   last;
    logic [IDX_W-1:0]       sel;

    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            pat_byte[k] = pattern_bits[BYTE_W*k +: BYTE_W];
        end

        len_ok = (pattern_len != '0) && (pattern_len <= MAX_LEN)
                 && (LEN_W'(fill) >= pattern_len);

        // Window entry j (newest first) lines up with pattern byte len-1-j.
        pidx = '0;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            pidx = pattern_len - LEN_W'(j) - LEN_W'(1);
            if (LEN_W'(j) < pattern_len) begin
                byte_ok[j] = (win_byte[j] == pat_byte[pidx[IDX_W-1:0]]);
            end else begin
                byte_ok[j] = 1'b1;
            end
        end

        last = pattern_len - LEN_W'(1);
        sel  = last[IDX_W-1:0];

        result.found = len_ok && (&byte_ok);
        if (result.found) begin
            result.line   = win_line[sel];
            result.column = win_column[sel];
            result.offset = item_offset - OFFSET_W'(last);
        end else begin
            result.line   = '0;
            result.column = '0;
            result.offset = '0;
        end
    end

endmodule

// ===== src/pattern_match_line_column.sv =====
`timescale 1ns / 1ps
// Top level of the streaming pattern finder with line, column and offset reporting.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+-------------------------------------------
//  s_      | in        | s_valid/s_ready   | s_text_byte, s_start_of_text
//  m_      | out       | m_valid/m_ready   | m_match_found, m_match_line,
//          |           |                   | m_match_column, m_match_offset
//  cfg_    | in        | cfg_we            | cfg_index, cfg_wdata
//
// Every text item yields exactly one result item, which is registered in the window
// registers and then in the output register, which holds it while the output stalls.
// An item is accepted every cycle while s_ready is high; the window shift line takes
// the byte on accept; the parallel compare fills the output register once it is free.
// Reset clears the configuration, the fill count and the position counters.
// If the output is stalled the compare stage holds, and s_ready drops only when
// both the compare stage and the output register are occupied.
module pattern_match_line_column
    import pmlc_pkg::*;
#(
    parameter int MAX_PATTERN = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_text_byte,
    input  logic                 s_start_of_text,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_match_found,
    output logic [23:0]          m_match_line,
    output logic [15:0]          m_match_column,
    output logic [31:0]          m_match_offset,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int FILL_W = $clog2(MAX_PATTERN + 1);

    // Pattern configuration.
    len_t                          pattern_len;
    logic [BYTE_W*MAX_PATTERN-1:0] pattern_bits;

    // Window state of the item in the compare stage.
    byte_t             win_byte   [MAX_PATTERN];
    line_t             win_line   [MAX_PATTERN];
    column_t           win_column [MAX_PATTERN];
    logic [FILL_W-1:0] fill;
    offset_t           item_offset;

    match_result_t     match_res;

    // Handshake and pipeline control.
    logic          busy_reg, busy_next;
    logic          out_valid_reg, out_valid_next;
    match_result_t out_reg;
    logic          out_free;
    logic          accept;

    pmlc_cfg_regs #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .pattern_len  (pattern_len),
        .pattern_bits (pattern_bits)
    );

    pmlc_window #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_window (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (accept),
        .text_byte     (s_text_byte),
        .start_of_text (s_start_of_text),
        .win_byte      (win_byte),
        .win_line      (win_line),
        .win_column    (win_column),
        .fill          (fill),
        .item_offset   (item_offset)
    );

    pmlc_match #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_match (
        .pattern_len  (pattern_len),
        .pattern_bits (pattern_bits),
        .win_byte     (win_byte),
        .win_line     (win_line),
        .win_column   (win_column),
        .fill         (fill),
        .item_offset  (item_offset),
        .result       (match_res)
    );

    // The output register can take a new result when it is empty or being drained.
    // The compare stage then moves on, which frees room for the next text item.
    always_comb begin
        out_free = !out_valid_reg || m_ready;
        s_ready  = !busy_reg || out_free;
        accept   = s_valid && s_ready;

        if (accept) begin
            busy_next = 1'b1;
        end else if (out_free) begin
            busy_next = 1'b0;
        end else begin
            busy_next = busy_reg;
        end

        out_valid_next = out_free ? busy_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && busy_reg) begin
            out_reg <= match_res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_match_found  = out_reg.found;
    assign m_match_line   = out_reg.line;
    assign m_match_column = out_reg.column;
    assign m_match_offset = out_reg.offset;

`ifndef ASSERT_OFF
    // A new item may only enter an occupied compare stage when that stage advances.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && busy_reg |-> out_free)
        else $error("item accepted over an unfinished compare stage");

    // A match needs a usable pattern length and enough bytes in the window.
    a_match_len: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && match_res.found |->
            pattern_len != '0 && LEN_W'(fill) >= pattern_len)
        else $error("match reported without a usable pattern length");

    // A start of text leaves exactly one byte in the window.
    a_restart_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_start_of_text |=> fill == FILL_W'(1))
        else $error("window fill not restarted by start of text");
`endif

endmodule
